@@ src/u8gd_pkg.sv @@
`default_nettype none

package u8gd_pkg;

	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] ASCII_LIMIT = 8'h80;

	localparam logic [15:0] LATIN_FIRST = 16'd32;
	localparam logic [15:0] LATIN_LIMIT = 16'd128;
	localparam logic [15:0] CYR_FIRST = 16'h0410;
	localparam logic [15:0] CYR_LAST = 16'h044F;
	localparam logic [15:0] CYR_IO_UPPER = 16'h0401;
	localparam logic [15:0] CYR_IO_LOWER = 16'h0451;
	localparam logic [6:0] SLOT_IE_UPPER = 7'd5;
	localparam logic [6:0] SLOT_IE_LOWER = 7'd37;
	localparam logic [6:0] SLOT_QUESTION = 7'd31;

	localparam logic TABLE_LATIN = 1'b0;
	localparam logic TABLE_CYRILLIC = 1'b1;

	localparam logic [1:0] HELD_NONE = 2'd0;
	localparam logic [1:0] HELD_LEAD = 2'd1;
	localparam logic [1:0] HELD_SECOND = 2'd2;

	typedef struct packed {
		logic [7:0] text_byte;
		logic string_end;
	} text_req_t;

	typedef struct packed {
		logic [15:0] code_point;
		logic glyph_table;
		logic [6:0] glyph_slot;
		logic text_done;
	} glyph_req_t;

	typedef struct packed {
		logic [1:0] count;
		glyph_req_t first;
		glyph_req_t second;
	} dec_res_t;

	function automatic logic is_lead2(input logic [7:0] b);
		return (b & LEAD2_MASK) == LEAD2_CODE;
	endfunction

	function automatic logic is_lead3(input logic [7:0] b);
		return (b & LEAD3_MASK) == LEAD3_CODE;
	endfunction

	function automatic glyph_req_t glyph_map(input logic [15:0] cp);
		glyph_req_t r;
		r.code_point = cp;
		r.text_done = 1'b0;
		if (cp >= LATIN_FIRST && cp < LATIN_LIMIT) begin
			r.glyph_table = TABLE_LATIN;
			r.glyph_slot = 7'(cp - LATIN_FIRST);
		end else if (cp >= CYR_FIRST && cp <= CYR_LAST) begin
			r.glyph_table = TABLE_CYRILLIC;
			r.glyph_slot = 7'(cp - CYR_FIRST);
		end else if (cp == CYR_IO_UPPER) begin
			r.glyph_table = TABLE_CYRILLIC;
			r.glyph_slot = SLOT_IE_UPPER;
		end else if (cp == CYR_IO_LOWER) begin
			r.glyph_table = TABLE_CYRILLIC;
			r.glyph_slot = SLOT_IE_LOWER;
		end else begin
			r.glyph_table = TABLE_LATIN;
			r.glyph_slot = SLOT_QUESTION;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ src/u8gd_decode.sv @@
`default_nettype none

module u8gd_decode (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step,
	input wire u8gd_pkg::text_req_t req,
	output u8gd_pkg::dec_res_t res
);

	logic [7:0] held_lead_q;
	logic [7:0] held_second_q;
	logic [1:0] held_count_q;

	logic [7:0] lead_d;
	logic [7:0] second_d;
	logic [1:0] count_d;

	logic [7:0] b;
	logic last;
	logic [15:0] cp2;
	logic [15:0] cp3;
	logic [15:0] cp_plain;

	assign b = req.text_byte;
	assign last = req.string_end;
	assign cp2 = {5'd0, held_lead_q[4:0], b[5:0]};
	assign cp3 = {held_lead_q[3:0], held_second_q[5:0], b[5:0]};
	// plain ascii passes through, everything else with no hold is malformed
	assign cp_plain = (b < u8gd_pkg::ASCII_LIMIT) ? {8'd0, b} : 16'd0;

	always_comb begin
		res.count = 2'd0;
		res.first = u8gd_pkg::glyph_map(16'd0);
		res.second = u8gd_pkg::glyph_map(cp_plain);
		lead_d = 8'd0;
		second_d = 8'd0;
		count_d = u8gd_pkg::HELD_NONE;
		unique case (held_count_q)
			u8gd_pkg::HELD_LEAD: begin
				if (u8gd_pkg::is_lead2(held_lead_q)) begin
					res.count = 2'd1;
					res.first = u8gd_pkg::glyph_map(cp2);
				end else if (!last) begin
					lead_d = held_lead_q;
					second_d = b;
					count_d = u8gd_pkg::HELD_SECOND;
				end else begin
					// cut-off three byte lead, then the byte again on its own
					res.count = 2'd2;
				end
			end
			u8gd_pkg::HELD_SECOND: begin
				res.count = 2'd1;
				res.first = u8gd_pkg::glyph_map(cp3);
			end
			default: begin
				if (b >= u8gd_pkg::ASCII_LIMIT && !last &&
						(u8gd_pkg::is_lead2(b) || u8gd_pkg::is_lead3(b))) begin
					lead_d = b;
					count_d = u8gd_pkg::HELD_LEAD;
				end else begin
					res.count = 2'd1;
					res.first = u8gd_pkg::glyph_map(cp_plain);
				end
			end
		endcase
		if (last) begin
			lead_d = 8'd0;
			second_d = 8'd0;
			count_d = u8gd_pkg::HELD_NONE;
			if (res.count == 2'd2) begin
				res.second.text_done = 1'b1;
			end else begin
				res.first.text_done = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_lead_q <= 8'd0;
			held_second_q <= 8'd0;
			held_count_q <= u8gd_pkg::HELD_NONE;
		end else if (step) begin
			held_lead_q <= lead_d;
			held_second_q <= second_d;
			held_count_q <= count_d;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q != 2'd3)
		else $error("held count out of range");

	a_pair_source: assert property (@(posedge clk) disable iff (!arst_n)
		res.count == 2'd2 |-> held_count_q == u8gd_pkg::HELD_LEAD && last &&
			u8gd_pkg::is_lead3(held_lead_q))
		else $error("two results without a cut-off three byte lead");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && last |=> held_count_q == u8gd_pkg::HELD_NONE)
		else $error("held bytes survive end of string");

	a_end_emits: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> res.count != 2'd0)
		else $error("end of string without a result");

endmodule

`default_nettype wire

@@ src/u8gd_outq.sv @@
`default_nettype none

module u8gd_outq #(
	parameter int DEPTH = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [1:0] push_n,
	input wire u8gd_pkg::glyph_req_t push_a,
	input wire u8gd_pkg::glyph_req_t push_b,
	output logic room,
	output logic glyph_valid,
	input wire logic glyph_stall,
	output u8gd_pkg::glyph_req_t glyph_req
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	u8gd_pkg::glyph_req_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] wr_next;
	logic [AW-1:0] wr_next2;
	logic pop;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign wr_next = ptr_inc(wr_ptr_q);
	assign wr_next2 = ptr_inc(wr_next);
	assign room = count_q <= CW'(DEPTH - 2);
	assign glyph_valid = count_q != '0;
	assign glyph_req = mem_q[rd_ptr_q];
	assign pop = glyph_valid && !glyph_stall;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push_a;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_next] <= push_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push_n == 2'd2) begin
				wr_ptr_q <= wr_next2;
			end else if (push_n == 2'd1) begin
				wr_ptr_q <= wr_next;
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + CW'(push_n) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("output queue overflow");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> room)
		else $error("push without room");

	a_pair_counts: assert property (@(posedge clk) disable iff (!arst_n)
		push_n == 2'd2 && !pop |=> count_q == $past(count_q) + CW'(2))
		else $error("paired push miscounted");

endmodule

`default_nettype wire

@@ src/utf8_glyph_index_decoder_unit.sv @@
`default_nettype none

// channel  | signals                          | carries
// ---------+----------------------------------+----------------------------------
// text     | text_valid text_stall text_req   | one byte and end-of-string flag
// glyph    | glyph_valid glyph_stall glyph_req| codepoint, table, slot, done flag
//
// one byte per cycle while the queue has room: input register, decode, result queue
// a byte advances only while the queue has room for two results
// a cut-off three byte lead at end of string pushes two results in one cycle
// reset clears held bytes and empties the input register and the queue; no clearing pass
// glyph_stall backs up into the queue, then into text_stall

module utf8_glyph_index_decoder_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic text_valid,
	output logic text_stall,
	input wire u8gd_pkg::text_req_t text_req,
	output logic glyph_valid,
	input wire logic glyph_stall,
	output u8gd_pkg::glyph_req_t glyph_req
);

	logic valid_s1;
	u8gd_pkg::text_req_t req_s1;
	u8gd_pkg::dec_res_t dec;
	logic room;
	logic adv;
	logic [1:0] push_n;

	assign adv = valid_s1 && room;
	assign text_stall = valid_s1 && !room;
	assign push_n = adv ? dec.count : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!text_stall) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!text_stall && text_valid) begin
			req_s1 <= text_req;
		end
	end

	u8gd_decode u_decode (
		.clk(clk),
		.arst_n(arst_n),
		.step(adv),
		.req(req_s1),
		.res(dec)
	);

	u8gd_outq #(
		.DEPTH(QUEUE_DEPTH)
	) u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push_n(push_n),
		.push_a(dec.first),
		.push_b(dec.second),
		.room(room),
		.glyph_valid(glyph_valid),
		.glyph_stall(glyph_stall),
		.glyph_req(glyph_req)
	);

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room |=> valid_s1 && $stable(req_s1))
		else $error("stalled request lost in input stage");

	a_empty_stage_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> push_n == 2'd0)
		else $error("results pushed without a request");

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		!room && valid_s1 |-> text_stall)
		else $error("input taken while queue has no room");

endmodule

`default_nettype wire
